// File: hw/rtl/f12_pkg.sv
// ----------------------------------------------------------------------------
// f12_pkg
// Shared word types and codes for the FAT12 table engine.
// ----------------------------------------------------------------------------
package f12_pkg;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_WRITE_BYTE = 3'd0;
    localparam kind_t KIND_READ_BYTE  = 3'd1;
    localparam kind_t KIND_GET_ENTRY  = 3'd2;
    localparam kind_t KIND_SET_ENTRY  = 3'd3;
    localparam kind_t KIND_FIND_FREE  = 3'd4;
    localparam kind_t KIND_ALLOCATE   = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_FREE = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;
    localparam status_t ST_LOOP    = 2'd3;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_END_MARKER  = 2'd0;
    localparam cfg_index_t CFG_END_THRESH  = 2'd1;
    localparam cfg_index_t CFG_ENTRIES_USE = 2'd2;

    localparam int CFG_DATA_W = 13;

    typedef struct packed {
        kind_t       kind;
        logic [12:0] byte_address;
        logic [7:0]  byte_value;
        logic [11:0] entry_index;
        logic [11:0] entry_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [11:0] entry_out;
        status_t     status;
    } out_word_t;

endpackage

// File: hw/rtl/f12_ram.sv
// ----------------------------------------------------------------------------
// f12_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module f12_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/fat12_table_engine.sv
// ----------------------------------------------------------------------------
// fat12_table_engine
// FAT12 allocation table held as a byte image in one RAM; raw byte access,
// 12-bit entry get/set, free search and allocate-and-link.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------
//  in       | in_valid / in_ready  | in_data   (f12_pkg::in_word_t)
//  out      | out_valid / out_ready| out_data  (f12_pkg::out_word_t)
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  One word at a time; every image access uses the single RAM port.
//  Raw byte: one access. Get entry: two byte reads. Set entry: two reads,
//  two writes. Find free: scan up from entry 0. Allocate: find, walk, mark, link.
//  Reset clears control only; the image is undefined until loaded.
//  A finished word waits in the output register; the next word may enter.
// ----------------------------------------------------------------------------
module fat12_table_engine #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  f12_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output f12_pkg::out_word_t            out_data,
    input  logic                          cfg_we,
    input  f12_pkg::cfg_index_t           cfg_index,
    input  logic [f12_pkg::CFG_DATA_W-1:0] cfg_data
);

    import f12_pkg::*;

    localparam int IMAGE_BYTES = MAX_ENTRIES + MAX_ENTRIES / 2;
    localparam int AW = $clog2(IMAGE_BYTES);
    localparam logic [13:0] IMAGE_LIM = 14'(IMAGE_BYTES);
    localparam logic [12:0] MAX_LIM = 13'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_RAW, S_RAW_CAP, S_ER0, S_ER1, S_ER2, S_EW0, S_EW1, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_GET, PH_SET, PH_FIND, PH_WALK, PH_MARK, PH_LINK
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    in_word_t    in_reg, in_next;
    logic [11:0] ent_reg, ent_next;
    logic [7:0]  b0_reg, b0_next;
    logic [7:0]  b1_reg, b1_next;
    logic [11:0] wval_reg, wval_next;
    logic [11:0] free_reg, free_next;
    logic [11:0] walk_cursor_reg, walk_cursor_next;
    logic [12:0] walk_steps_reg, walk_steps_next;
    out_word_t   res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic [11:0] end_marker_reg;
    logic [11:0] end_thresh_reg;
    logic [12:0] entries_use_reg;

    logic [12:0] lim;
    logic [12:0] off;
    logic [12:0] off1;
    logic [11:0] entry;
    logic [12:0] ent_inc;
    logic [7:0]  wb0;
    logic [7:0]  wb1;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    f12_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign lim     = (entries_use_reg < MAX_LIM) ? entries_use_reg : MAX_LIM;
    assign off     = {1'b0, ent_reg} + {2'b0, ent_reg[11:1]};
    assign off1    = off + 13'd1;
    assign ent_inc = {1'b0, ent_reg} + 13'd1;
    assign entry   = ent_reg[0] ? {ram_rdata, b0_reg[7:4]} : {ram_rdata[3:0], b0_reg};
    assign wb0     = ent_reg[0] ? {wval_reg[3:0], b0_reg[3:0]} : wval_reg[7:0];
    assign wb1     = ent_reg[0] ? wval_reg[11:4] : {b1_reg[7:4], wval_reg[11:8]};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = off[AW-1:0];
        ram_wdata = wb0;
        unique case (state_reg)
            S_RAW:
            begin
                ram_addr  = in_reg.byte_address[AW-1:0];
                ram_wdata = in_reg.byte_value;
                ram_we    = (in_reg.kind == KIND_WRITE_BYTE);
            end
            S_ER1:   ram_addr = off1[AW-1:0];
            S_EW0:   ram_we = 1'b1;
            S_EW1:
            begin
                ram_we    = 1'b1;
                ram_addr  = off1[AW-1:0];
                ram_wdata = wb1;
            end
            default: ram_addr = off[AW-1:0];
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        in_next          = in_reg;
        ent_next         = ent_reg;
        b0_next          = b0_reg;
        b1_next          = b1_reg;
        wval_next        = wval_reg;
        free_next        = free_reg;
        walk_cursor_next = walk_cursor_reg;
        walk_steps_next  = walk_steps_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_data;
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (in_data.kind)
                        KIND_WRITE_BYTE, KIND_READ_BYTE:
                        begin
                            if ({1'b0, in_data.byte_address} < IMAGE_LIM)
                                state_next = S_RAW;
                            else
                                res_next.status = ST_RANGE;
                        end
                        KIND_GET_ENTRY, KIND_SET_ENTRY:
                        begin
                            if ({1'b0, in_data.entry_index} < lim)
                            begin
                                ent_next   = in_data.entry_index;
                                wval_next  = in_data.entry_value;
                                phase_next = (in_data.kind == KIND_GET_ENTRY) ?
                                             PH_GET : PH_SET;
                                state_next = S_ER0;
                            end
                            else
                                res_next.status = ST_RANGE;
                        end
                        KIND_FIND_FREE, KIND_ALLOCATE:
                        begin
                            if (lim != 13'd0)
                            begin
                                ent_next   = '0;
                                phase_next = PH_FIND;
                                state_next = S_ER0;
                            end
                            else
                                res_next.status = ST_NO_FREE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RAW:
            begin
                state_next = (in_reg.kind == KIND_READ_BYTE) ? S_RAW_CAP : S_DONE;
            end
            S_RAW_CAP:
            begin
                res_next.read_byte = ram_rdata;
                state_next = S_DONE;
            end
            S_ER0: state_next = S_ER1;
            S_ER1:
            begin
                b0_next    = ram_rdata;
                state_next = S_ER2;
            end
            S_ER2:
            begin
                b1_next = ram_rdata;
                unique case (phase_reg)
                    PH_GET:
                    begin
                        res_next.entry_out = entry;
                        state_next = S_DONE;
                    end
                    PH_SET, PH_MARK, PH_LINK: state_next = S_EW0;
                    PH_FIND:
                    begin
                        if (entry == 12'd0)
                        begin
                            free_next = ent_reg;
                            if (in_reg.kind == KIND_FIND_FREE)
                            begin
                                res_next.entry_out = ent_reg;
                                state_next = S_DONE;
                            end
                            else if ({1'b0, in_reg.entry_index} >= lim)
                            begin
                                res_next.status = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                walk_cursor_next = in_reg.entry_index;
                                walk_steps_next  = '0;
                                ent_next   = in_reg.entry_index;
                                phase_next = PH_WALK;
                                state_next = S_ER0;
                            end
                        end
                        else if (ent_inc >= lim)
                        begin
                            res_next.status = ST_NO_FREE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ent_next   = ent_inc[11:0];
                            state_next = S_ER0;
                        end
                    end
                    PH_WALK:
                    begin
                        if (entry >= end_thresh_reg)
                        begin
                            ent_next   = free_reg;
                            wval_next  = end_marker_reg;
                            phase_next = PH_MARK;
                            state_next = S_ER0;
                        end
                        else if ({1'b0, entry} >= lim)
                        begin
                            res_next.status = ST_RANGE;
                            state_next = S_DONE;
                        end
                        else if (walk_steps_reg >= lim)
                        begin
                            res_next.status = ST_LOOP;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            walk_cursor_next = entry;
                            walk_steps_next  = walk_steps_reg + 13'd1;
                            ent_next   = entry;
                            state_next = S_ER0;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_EW0: state_next = S_EW1;
            S_EW1:
            begin
                state_next = S_DONE;
                if (phase_reg == PH_MARK)
                begin
                    ent_next   = walk_cursor_reg;
                    wval_next  = free_reg;
                    phase_next = PH_LINK;
                    state_next = S_ER0;
                end
                else if (phase_reg == PH_LINK)
                    res_next.entry_out = free_reg;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_GET;
            out_valid_reg   <= 1'b0;
            walk_cursor_reg <= '0;
            walk_steps_reg  <= '0;
            end_marker_reg  <= 12'd4095;
            end_thresh_reg  <= 12'd4088;
            entries_use_reg <= 13'd3072;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
            walk_cursor_reg <= walk_cursor_next;
            walk_steps_reg  <= walk_steps_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_END_MARKER:  end_marker_reg  <= cfg_data[11:0];
                    CFG_END_THRESH:  end_thresh_reg  <= cfg_data[11:0];
                    CFG_ENTRIES_USE: entries_use_reg <= cfg_data;
                    default:         end_marker_reg  <= end_marker_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        ent_reg      <= ent_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        wval_reg     <= wval_next;
        free_reg     <= free_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: hw/rtl/f12_chk.sv
// ----------------------------------------------------------------------------
// f12_chk
// Port-level checks for the FAT12 table engine, bound to the top level.
// ----------------------------------------------------------------------------
module f12_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input f12_pkg::out_word_t out_data
);

    import f12_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.read_byte != 8'd0) |-> out_data.status == ST_OK)
        else $error("byte returned with error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.entry_out == 12'd0)
        else $error("entry value returned with error status");

endmodule

bind fat12_table_engine f12_chk u_f12_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
